### design/cmat_pkg.sv
`default_nettype none
package cmat_pkg;

  localparam int VECTOR_LEN   = 512;
  localparam int TABLE_DEPTH  = 32;
  localparam int ELEMENT_BITS = 16;

  localparam int FRAC_BITS = ELEMENT_BITS - 1;
  localparam int PROD_W    = 2 * ELEMENT_BITS;
  // full dot sum of VECTOR_LEN products plus sign headroom
  localparam int ACC_W     = PROD_W + $clog2(VECTOR_LEN) + 1;
  localparam int POS_W     = $clog2(VECTOR_LEN + 1);
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int ROW_W     = $clog2(TABLE_DEPTH + 1);
  localparam int ROWS      = TABLE_DEPTH + 1;
  localparam int ADDR_W    = $clog2(ROWS * VECTOR_LEN);

  localparam int THR_W     = 16;
  localparam int SCORE_W   = 16;
  localparam int TRACK_W   = 5;
  localparam int USE_W     = 6;
  localparam logic signed [THR_W-1:0] THR_RESET = 16'sd18022;

  typedef struct packed {
    logic signed [ELEMENT_BITS-1:0] feature_value;
    logic                           last_element;
  } in_t;

  typedef struct packed {
    logic [TRACK_W-1:0]        track_slot;
    logic signed [SCORE_W-1:0] best_score;
    logic                      matched;
    logic                      added;
    logic                      table_full;
    logic [USE_W-1:0]          entries_in_use;
  } out_t;

  // one table slot: physical RAM row, valid length of that row, dot accumulator
  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [POS_W-1:0]        len;
    logic signed [ACC_W-1:0] acc;
  } cell_t;

  typedef struct packed {
    logic row_en;
    logic acc_en;
  } cell_ctl_t;

endpackage
`default_nettype wire

### design/cmat_ram.sv
`default_nettype none
module cmat_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### design/cmat_cell.sv
`default_nettype none
module cmat_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cmat_pkg::cell_ctl_t        ctl,
  input  wire logic [cmat_pkg::ROW_W-1:0] init_row,
  input  wire cmat_pkg::cell_t            d,
  output cmat_pkg::cell_t                 q
);

  cmat_pkg::cell_t q_r;

  // row/len and accumulator rotate on separate enables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.row <= init_row;
      q_r.len <= '0;
      q_r.acc <= '0;
    end else begin
      if (ctl.row_en) begin
        q_r.row <= d.row;
        q_r.len <= d.len;
      end
      if (ctl.acc_en) begin
        q_r.acc <= d.acc;
      end
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

### design/cosine_match_or_add_table.sv
// Channel | Ports                              | Moves
// in      | in_valid, in_ready, in_data        | one feature element per request
// out     | out_valid, out_ready, out_data     | one result per vector, on last element
// cfg     | cfg_we, cfg_wdata                  | similarity threshold write
//
// For each element the cell chain rotates once past the single RAM read port and
// the shared multiply-accumulate. Elements past VECTOR_LEN skip the rotation. A last
// element adds a best-score scan, a decision state and, unless the table is full, a
// slot remap pass over all TABLE_DEPTH slots.
// Reset is synchronous; no clearing pass (row lengths gate reads).
// A pending result stalls only the decision state; in_ready is high when idle.
`default_nettype none
module cosine_match_or_add_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire cmat_pkg::in_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output cmat_pkg::out_t                  out_data,
  input  wire logic                       cfg_we,
  input  wire logic [cmat_pkg::THR_W-1:0] cfg_wdata
);

  localparam int D     = cmat_pkg::TABLE_DEPTH;
  localparam int ACC_W = cmat_pkg::ACC_W;
  localparam int EB    = cmat_pkg::ELEMENT_BITS;
  localparam int FB    = cmat_pkg::FRAC_BITS;
  localparam int AW    = cmat_pkg::ADDR_W;
  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(-32768);

  typedef enum logic [2:0] {ST_IDLE, ST_ACC, ST_SCAN, ST_DECIDE, ST_COMMIT} state_t;

  state_t                           state_r;
  logic [cmat_pkg::POS_W-1:0]       pos_r;
  logic [cmat_pkg::POS_W-1:0]       p_r;
  logic [cmat_pkg::CNT_W-1:0]       cnt_r;
  logic [cmat_pkg::CNT_W-1:0]       k_r;
  logic [cmat_pkg::CNT_W-1:0]       tgt_r;
  logic [cmat_pkg::CNT_W-1:0]       bidx_r;
  logic [cmat_pkg::ROW_W-1:0]       spare_row_r;
  logic signed [cmat_pkg::THR_W-1:0] thr_r;
  logic signed [EB-1:0]             x_r;
  logic                             last_r;
  logic                             s1_v_r, s1_use_r, s2_v_r;
  logic signed [cmat_pkg::PROD_W-1:0] prod_r;
  logic                             have_r;
  logic signed [ACC_W-1:0]          best_r;
  logic                             out_valid_r;
  cmat_pkg::out_t                   out_r;

  cmat_pkg::cell_t     cell_q [D];
  cmat_pkg::cell_t     cell_d [D];
  cmat_pkg::cell_t     tail;
  cmat_pkg::cell_ctl_t ctl;

  logic            accept;
  logic            issuing;
  logic [AW-1:0]   raddr, waddr;
  logic [EB-1:0]   rdata;
  logic            k_live;
  logic signed [ACC_W-1:0] thr_q, shifted, score;
  logic            match_c, add_c;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign issuing  = (state_r == ST_ACC) && (k_r < cmat_pkg::CNT_W'(D));
  assign k_live   = (k_r < cnt_r);

  assign raddr = AW'(cell_q[0].row) * AW'(cmat_pkg::VECTOR_LEN) + AW'(p_r);
  assign waddr = AW'(spare_row_r) * AW'(cmat_pkg::VECTOR_LEN) + AW'(pos_r);

  cmat_ram #(
    .WIDTH (EB),
    .DEPTH (cmat_pkg::ROWS * cmat_pkg::VECTOR_LEN),
    .ADDR_W(AW)
  ) u_ram (
    .clk  (clk),
    .we   (accept && (pos_r < cmat_pkg::POS_W'(cmat_pkg::VECTOR_LEN))),
    .waddr(waddr),
    .wdata(in_data.feature_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign ctl.row_en = issuing || (state_r == ST_COMMIT);
  assign ctl.acc_en = ((state_r == ST_ACC) && s2_v_r) || (state_r == ST_SCAN);

  always_comb begin
    tail = cell_q[0];
    if (state_r == ST_ACC) begin
      tail.acc = cell_q[0].acc + ACC_W'(prod_r);
    end else if (state_r == ST_SCAN) begin
      tail.acc = '0;
    end
    // remap: the target slot takes the freshly written row, old row becomes spare
    if ((state_r == ST_COMMIT) && (k_r == tgt_r)) begin
      tail.row = spare_row_r;
      tail.len = pos_r;
    end
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    if (i == D - 1) begin : g_tail
      assign cell_d[i] = tail;
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end
    cmat_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .init_row(cmat_pkg::ROW_W'(i)),
      .d       (cell_d[i]),
      .q       (cell_q[i])
    );
  end

  always_comb begin
    thr_q   = {{(ACC_W - cmat_pkg::THR_W - FB){thr_r[cmat_pkg::THR_W-1]}}, thr_r, FB'(0)};
    shifted = best_r >>> FB;
    if (!have_r) begin
      score = SMIN;
    end else if (shifted > SMAX) begin
      score = SMAX;
    end else if (shifted < SMIN) begin
      score = SMIN;
    end else begin
      score = shifted;
    end
    match_c = have_r && (best_r >= thr_q);
    add_c   = !match_c && (cnt_r < cmat_pkg::CNT_W'(D));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      spare_row_r <= cmat_pkg::ROW_W'(D);
      thr_r       <= cmat_pkg::THR_RESET;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if ((state_r == ST_DECIDE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // multiply pipeline: RAM read, then registered product
      s1_v_r   <= issuing;
      s1_use_r <= k_live && (p_r < cell_q[0].len);
      s2_v_r   <= s1_v_r;
      if (s1_use_r) begin
        prod_r <= x_r * $signed(rdata);
      end else begin
        prod_r <= '0;
      end

      case (state_r)
        ST_IDLE: begin
          k_r    <= '0;
          have_r <= 1'b0;
          if (accept) begin
            x_r    <= in_data.feature_value;
            p_r    <= pos_r;
            last_r <= in_data.last_element;
            if (pos_r < cmat_pkg::POS_W'(cmat_pkg::VECTOR_LEN)) begin
              pos_r   <= pos_r + 1'b1;
              state_r <= ST_ACC;
            end else if (in_data.last_element) begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_ACC: begin
          if (issuing) begin
            k_r <= k_r + 1'b1;
          end else if (!s1_v_r && !s2_v_r) begin
            k_r     <= '0;
            state_r <= last_r ? ST_SCAN : ST_IDLE;
          end
        end
        ST_SCAN: begin
          // strict compare keeps the lower index on a tie
          if (k_live && (!have_r || (cell_q[0].acc > best_r))) begin
            have_r <= 1'b1;
            best_r <= cell_q[0].acc;
            bidx_r <= k_r;
          end
          if (k_r == cmat_pkg::CNT_W'(D - 1)) begin
            k_r     <= '0;
            state_r <= ST_DECIDE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_DECIDE: begin
          if (!out_valid_r || out_ready) begin
            out_r.best_score    <= score[cmat_pkg::SCORE_W-1:0];
            out_r.matched       <= match_c;
            out_r.added         <= add_c;
            out_r.table_full    <= !match_c && !add_c;
            if (match_c) begin
              out_r.track_slot   <= cmat_pkg::TRACK_W'(bidx_r);
              out_r.entries_in_use <= cmat_pkg::USE_W'(cnt_r);
              tgt_r              <= bidx_r;
              state_r            <= ST_COMMIT;
            end else if (add_c) begin
              out_r.track_slot   <= cmat_pkg::TRACK_W'(cnt_r);
              out_r.entries_in_use <= cmat_pkg::USE_W'(cnt_r + 1'b1);
              cnt_r              <= cnt_r + 1'b1;
              tgt_r              <= cnt_r;
              state_r            <= ST_COMMIT;
            end else begin
              out_r.track_slot   <= '0;
              out_r.entries_in_use <= cmat_pkg::USE_W'(cnt_r);
              pos_r              <= '0;
              state_r            <= ST_IDLE;
            end
          end
        end
        ST_COMMIT: begin
          if (k_r == tgt_r) begin
            spare_row_r <= cell_q[0].row;
          end
          if (k_r == cmat_pkg::CNT_W'(D - 1)) begin
            k_r     <= '0;
            pos_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### design/cmat_checker.sv
`default_nettype none
module cmat_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire cmat_pkg::out_t             out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_data.matched, out_data.added, out_data.table_full}))
    else $error("result must be exactly one of match, add, full");

  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |->
      out_data.track_slot == '0 &&
      out_data.entries_in_use == cmat_pkg::USE_W'(cmat_pkg::TABLE_DEPTH))
    else $error("full flag with free slots or nonzero slot");

  a_add_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.added |->
      cmat_pkg::USE_W'(out_data.track_slot) + 1'b1 == out_data.entries_in_use)
    else $error("added slot does not match entry count");

endmodule

bind cosine_match_or_add_table cmat_checker u_cmat_checker (.*);
`default_nettype wire

### bench/cosine_match_or_add_table_chk.sv
`default_nettype none
module cosine_match_or_add_table_chk (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire cmat_pkg::in_t              in_data,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire cmat_pkg::out_t             out_data,
  input  wire logic                       cfg_we,
  input  wire logic [cmat_pkg::THR_W-1:0] cfg_wdata,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [cmat_pkg::ELEMENT_BITS-1:0]
    track_mem [cmat_pkg::TABLE_DEPTH][cmat_pkg::VECTOR_LEN];
  logic signed [cmat_pkg::ELEMENT_BITS-1:0] new_vec [cmat_pkg::VECTOR_LEN];
  longint                         dot_sum [cmat_pkg::TABLE_DEPTH];
  int                             live_cnt;
  int                             elem_pos;
  logic signed [cmat_pkg::THR_W-1:0] thr;
  cmat_pkg::out_t                 want_q [$];

  initial errors = 0;
  initial pending = 0;

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // fold one element in; on the last one decide match/add/full
  task automatic absorb(cmat_pkg::in_t d);
    longint best, lim, sc;
    int     best_j, slot;
    bit     have, hit, add, full;
    cmat_pkg::out_t r;
    if (elem_pos < cmat_pkg::VECTOR_LEN) begin
      new_vec[elem_pos] = d.feature_value;
      for (int j = 0; j < live_cnt; j++)
        dot_sum[j] += longint'(d.feature_value) * longint'(track_mem[j][elem_pos]);
      elem_pos++;
    end
    if (!d.last_element) return;
    for (int p = elem_pos; p < cmat_pkg::VECTOR_LEN; p++) new_vec[p] = '0;
    have = 0; best = 0; best_j = 0; hit = 0; add = 0; full = 0; slot = 0;
    for (int j = 0; j < live_cnt; j++)
      if (!have || dot_sum[j] > best) begin
        best = dot_sum[j];
        best_j = j;
        have = 1;
      end
    lim = longint'(thr) * 32768;
    if (have && best >= lim) begin
      hit = 1;
      slot = best_j;
    end else if (live_cnt < cmat_pkg::TABLE_DEPTH) begin
      add = 1;
      slot = live_cnt;
      live_cnt++;
    end else begin
      full = 1;
    end
    if (hit || add)
      for (int p = 0; p < cmat_pkg::VECTOR_LEN; p++) track_mem[slot][p] = new_vec[p];
    if (!have) sc = -32768;
    else begin
      sc = best >>> cmat_pkg::FRAC_BITS;
      if (sc > 32767) sc = 32767;
      if (sc < -32768) sc = -32768;
    end
    r.track_slot     = slot[cmat_pkg::TRACK_W-1:0];
    r.best_score     = sc[cmat_pkg::SCORE_W-1:0];
    r.matched        = hit;
    r.added          = add;
    r.table_full     = full;
    r.entries_in_use = live_cnt[cmat_pkg::USE_W-1:0];
    want_q = {want_q, r};
    for (int j = 0; j < cmat_pkg::TABLE_DEPTH; j++) dot_sum[j] = 0;
    elem_pos = 0;
  endtask

  always @(posedge clk) begin
    cmat_pkg::out_t w;
    if (!rst_n) begin
      live_cnt = 0;
      elem_pos = 0;
      thr = cmat_pkg::THR_RESET;
      for (int j = 0; j < cmat_pkg::TABLE_DEPTH; j++) dot_sum[j] = 0;
      want_q.delete();
    end else begin
      if (cfg_we) thr = cfg_wdata;
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) report("unexpected result", out_data, 0);
        else begin
          w = want_q.pop_front();
          if (out_data.track_slot != w.track_slot)
            report("track_slot", out_data.track_slot, w.track_slot);
          if (out_data.best_score != w.best_score)
            report("best_score", out_data.best_score, w.best_score);
          if (out_data.matched != w.matched)
            report("matched", out_data.matched, w.matched);
          if (out_data.added != w.added)
            report("added", out_data.added, w.added);
          if (out_data.table_full != w.table_full)
            report("table_full", out_data.table_full, w.table_full);
          if (out_data.entries_in_use != w.entries_in_use)
            report("entries_in_use", out_data.entries_in_use, w.entries_in_use);
        end
      end
      if (in_valid && in_ready) absorb(in_data);
    end
    pending = want_q.size();
  end
endmodule
`default_nettype wire

### bench/cosine_match_or_add_table_tb.sv
`default_nettype none
module cosine_match_or_add_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_valid = 0;
  logic             in_ready;
  cmat_pkg::in_t    in_data = '0;
  logic             out_valid;
  logic             out_ready = 0;
  cmat_pkg::out_t   out_data;
  logic             cfg_we = 0;
  logic [cmat_pkg::THR_W-1:0] cfg_wdata = '0;
  int               errors, pending;
  int               sent = 0;
  bit               fast_tx = 0, fast_rx = 0, took = 0;
  int               rx_stall = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  cosine_match_or_add_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  cosine_match_or_add_table_chk u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending)
  );

  // result side stalls
  always @(posedge clk) took <= rst_n && out_valid && out_ready;
  always @(negedge clk) begin
    if (took) rx_stall = fast_rx ? 0 : $urandom_range(0, 17);
    if (rx_stall > 0) begin
      out_ready <= 0;
      rx_stall--;
    end else out_ready <= 1;
  end

  task automatic send(logic signed [15:0] v, bit last);
    int gap;
    gap = fast_tx ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data.feature_value <= v;
    in_data.last_element <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_vec(int len);
    for (int i = 0; i < len; i++) send(pick_value(), i == len - 1);
  endtask

  // hold off until every result is in and the remap pass is over
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic set_thr(logic [15:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    int phase;
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // empty table, then a repeat that should match, then a zero vector
    send(16'sh7fff, 0); send(16'sh8000, 1);
    send(16'sh7fff, 0); send(16'sh8000, 1);
    send(16'sh0000, 1);
    send(16'sh8000, 0); send(16'sh8000, 0); send(16'sh7fff, 1);
    send(16'shffff, 1);
    // max threshold: nearly always add, so the table fills up
    set_thr(16'h7fff);
    fast_tx = 1;
    for (int k = 0; k < 36; k++) send_vec($urandom_range(1, 2));
    fast_tx = 0;
    set_thr(16'h8000);
    send_vec(4); send_vec(1);
    // vector longer than the table row
    send_vec(cmat_pkg::VECTOR_LEN + 3);
    set_thr(16'h0000);
    phase = 0;
    while (sent < 1250) begin
      fast_tx = (phase % 3 == 1);
      fast_rx = (phase % 4 == 2);
      for (int k = 0; k < 40 && sent < 1250; k++) send_vec($urandom_range(1, 8));
      phase++;
      set_thr(16'($urandom()));
    end
    drain();
    if (errors == 0 && pending == 0) $display("cosine_match_or_add_table_tb passed");
    else $display("cosine_match_or_add_table_tb failed");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("cosine_match_or_add_table_tb failed");
    $finish;
  end
endmodule
`default_nettype wire
